/* sv/gcd_by_prime_factorization_assert.svh */
// ----------------------------------------------------------------------------
// GCD by prime factorization: assertion macros
// Short forms for the concurrent checks. Every check samples on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GCD_BY_PRIME_FACTORIZATION_ASSERT_SVH
`define GCD_BY_PRIME_FACTORIZATION_ASSERT_SVH

// The condition holds at every clock edge.
`define GCDPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define GCDPF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GCDPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gcdpf_pkg.sv */
// ----------------------------------------------------------------------------
// GCD by prime factorization: package
// Default sizes and the status codes of the result channel.
// ----------------------------------------------------------------------------
package gcdpf_pkg;

    // Default operand width and factor list depth.
    localparam int OPERAND_BITS_DEF = 31;
    localparam int MAX_PRIMES_DEF   = 9;

    // Width of the divisor field of a result.
    localparam int DIVISOR_BITS = 31;

    // Status codes of a result.
    localparam logic STATUS_VALID     = 1'b0;
    localparam logic STATUS_UNDEFINED = 1'b1;

endpackage

/* sv/gcd_by_prime_factorization.sv */
// ----------------------------------------------------------------------------
// GCD by prime factorization
// Greatest common divisor of two operands, found by factoring each operand
// with trial division and multiplying the shared primes at their smaller
// exponents.
// ----------------------------------------------------------------------------
// One item is worked on at a time: item_ready is high only while the block is
// idle, and it returns in the cycle after the result transfer. An operand
// below two gives status undefined and divisor 0 in the cycle after the input
// transfer. Otherwise each operand first sheds its factors of two, then every
// trial divisor runs through the shared add/subtract unit, which forms one
// quotient bit per cycle; trial divisors run over the odd numbers up to the
// square root of the remaining cofactor, so a large prime operand is the
// worst case. The closing merge multiplies in each shared prime on the same
// unit, negligible beside the factoring. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module gcd_by_prime_factorization
    import gcdpf_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF,
    parameter int MAX_PRIMES   = MAX_PRIMES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [OPERAND_BITS-1:0] first_value,
    input  logic [OPERAND_BITS-1:0] second_value,

    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [DIVISOR_BITS-1:0] divisor,
    output logic                    status
);

    localparam int W     = OPERAND_BITS;
    localparam int AW    = OPERAND_BITS + 2;
    localparam int PW    = $clog2(OPERAND_BITS + 1);
    localparam int CW    = $clog2(MAX_PRIMES + 1);
    localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int BW    = $clog2(OPERAND_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_DIV,
        S_EVAL,
        S_LEFT,
        S_MERGE,
        S_MUL,
        S_DONE
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    logic              sel_reg, sel_next;
    logic              inner_reg, inner_next;
    logic [BW-1:0]     step_reg, step_next;
    logic [CW-1:0]     cnt_reg [2];
    logic [CW-1:0]     cnt_next [2];
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [PW-1:0]     e_reg, e_next;
    logic              result_valid_reg, result_valid_next;

    // Datapath registers.
    logic [W-1:0]      x_reg, x_next;
    logic [W-1:0]      b_reg, b_next;
    logic [W-1:0]      d_reg, d_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      g_reg, g_next;
    logic [W-1:0]      mprime_reg, mprime_next;
    logic [W-1:0]      last_prime_reg, last_prime_next;
    logic [PW-1:0]     cur_pow_reg, cur_pow_next;
    logic [W-1:0]      prime_reg [2][MAX_PRIMES];
    logic [W-1:0]      prime_next [2][MAX_PRIMES];
    logic [PW-1:0]     power_reg [2][MAX_PRIMES];
    logic [PW-1:0]     power_next [2][MAX_PRIMES];
    logic [DIVISOR_BITS-1:0] divisor_reg, divisor_next;
    logic              status_reg, status_next;

    // Shared add/subtract unit.
    logic [AW-1:0]     add_a;
    logic [AW-1:0]     add_b;
    logic              add_sub;
    logic [AW-1:0]     add_sum;
    logic [W:0]        trial;
    logic              no_borrow;

    // Factor list append request.
    logic              af_en;
    logic [W-1:0]      af_p;
    logic [CW-1:0]     cnt_cur;
    logic [CW-1:0]     cnt_m1;

    // Merge operands.
    logic [W-1:0]      pa;
    logic [W-1:0]      pb;
    logic [PW-1:0]     ea;
    logic [PW-1:0]     eb;
    logic              last_step;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign divisor      = divisor_reg;
    assign status       = status_reg;

    // The unit divides one bit a step in S_DIV and multiplies one bit a step
    // otherwise, most significant multiplier bit first.
    assign trial = {rem_reg, quo_reg[W-1]};

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            add_a   = {1'b0, trial};
            add_b   = {2'b00, d_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = {2'b00, rem_reg[W-2:0], 1'b0};
            add_b   = quo_reg[W-1] ? {2'b00, g_reg} : '0;
            add_sub = 1'b0;
        end
        add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    end

    assign no_borrow = ~add_sum[AW-1];
    assign last_step = (step_reg == BW'(W - 1));

    assign cnt_cur = cnt_reg[sel_reg];
    assign cnt_m1  = cnt_cur - CW'(1);

    assign pa = prime_reg[0][i_reg[IDX_W-1:0]];
    assign pb = prime_reg[1][j_reg[IDX_W-1:0]];
    assign ea = power_reg[0][i_reg[IDX_W-1:0]];
    assign eb = power_reg[1][j_reg[IDX_W-1:0]];

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        sel_next          = sel_reg;
        inner_next        = inner_reg;
        step_next         = step_reg;
        cnt_next          = cnt_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        e_next            = e_reg;
        result_valid_next = result_valid_reg;
        x_next            = x_reg;
        b_next            = b_reg;
        d_next            = d_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        g_next            = g_reg;
        mprime_next       = mprime_reg;
        divisor_next      = divisor_reg;
        status_next       = status_reg;
        af_en             = 1'b0;
        af_p              = x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (first_value < W'(2) || second_value < W'(2))
                    begin
                        divisor_next      = '0;
                        status_next       = STATUS_UNDEFINED;
                        result_valid_next = 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        x_next      = first_value;
                        b_next      = second_value;
                        sel_next    = 1'b0;
                        cnt_next[0] = '0;
                        cnt_next[1] = '0;
                        state_next  = S_TWOS;
                    end
                end
            end

            // Strip factors of two with a shift.
            S_TWOS:
            begin
                if (!x_reg[0])
                begin
                    af_en  = 1'b1;
                    af_p   = W'(2);
                    x_next = x_reg >> 1;
                end
                else
                begin
                    d_next     = W'(3);
                    quo_next   = x_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    inner_next = 1'b0;
                    state_next = S_DIV;
                end
            end

            // Restoring division of the cofactor by the trial divisor.
            S_DIV:
            begin
                rem_next  = no_borrow ? add_sum[W-1:0] : trial[W-1:0];
                quo_next  = {quo_reg[W-2:0], no_borrow};
                step_next = step_reg + BW'(1);
                if (last_step)
                begin
                    state_next = S_EVAL;
                end
            end

            // Quotient in quo_reg, remainder in rem_reg.
            S_EVAL:
            begin
                step_next = '0;
                rem_next  = '0;
                if (!inner_reg && d_reg > quo_reg)
                begin
                    state_next = S_LEFT;
                end
                else if (rem_reg == '0)
                begin
                    af_en      = 1'b1;
                    af_p       = d_reg;
                    x_next     = quo_reg;
                    quo_next   = quo_reg;
                    inner_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    d_next     = d_reg + W'(2);
                    quo_next   = x_reg;
                    inner_next = 1'b0;
                    state_next = S_DIV;
                end
            end

            // A cofactor above one is one more prime.
            S_LEFT:
            begin
                if (x_reg != W'(1))
                begin
                    af_en = 1'b1;
                    af_p  = x_reg;
                end
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    x_next     = b_reg;
                    state_next = S_TWOS;
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    g_next     = W'(1);
                    state_next = S_MERGE;
                end
            end

            // Walk both sorted lists for primes they share.
            S_MERGE:
            begin
                if (i_reg < cnt_reg[0] && j_reg < cnt_reg[1])
                begin
                    if (pa < pb)
                    begin
                        i_next = i_reg + CW'(1);
                    end
                    else if (pa > pb)
                    begin
                        j_next = j_reg + CW'(1);
                    end
                    else
                    begin
                        e_next      = (ea < eb) ? ea : eb;
                        mprime_next = pa;
                        quo_next    = pa;
                        rem_next    = '0;
                        step_next   = '0;
                        state_next  = S_MUL;
                    end
                end
                else
                begin
                    divisor_next      = DIVISOR_BITS'(g_reg);
                    status_next       = STATUS_VALID;
                    result_valid_next = 1'b1;
                    state_next        = S_DONE;
                end
            end

            // Shift-add multiplication of the running product by the prime.
            S_MUL:
            begin
                rem_next  = add_sum[W-1:0];
                quo_next  = quo_reg << 1;
                step_next = step_reg + BW'(1);
                if (last_step)
                begin
                    g_next    = add_sum[W-1:0];
                    e_next    = e_reg - PW'(1);
                    step_next = '0;
                    if (e_reg == PW'(1))
                    begin
                        i_next     = i_reg + CW'(1);
                        j_next     = j_reg + CW'(1);
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        quo_next = mprime_reg;
                        rem_next = '0;
                    end
                end
            end

            S_DONE:
            begin
                if (result_ready)
                begin
                    result_valid_next = 1'b0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append a prime to the list in work, or raise the exponent of the
        // last one. A new prime is dropped once the list is full.
        last_prime_next = last_prime_reg;
        cur_pow_next    = cur_pow_reg;
        prime_next      = prime_reg;
        power_next      = power_reg;
        if (af_en)
        begin
            if (cnt_cur != '0 && last_prime_reg == af_p)
            begin
                cur_pow_next = cur_pow_reg + PW'(1);
                power_next[sel_reg][cnt_m1[IDX_W-1:0]] = cur_pow_reg + PW'(1);
            end
            else if (cnt_cur < CW'(MAX_PRIMES))
            begin
                prime_next[sel_reg][cnt_cur[IDX_W-1:0]] = af_p;
                power_next[sel_reg][cnt_cur[IDX_W-1:0]] = PW'(1);
                last_prime_next       = af_p;
                cur_pow_next          = PW'(1);
                cnt_next[sel_reg]     = cnt_cur + CW'(1);
            end
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sel_reg          <= 1'b0;
            inner_reg        <= 1'b0;
            step_reg         <= '0;
            cnt_reg          <= '{default: '0};
            i_reg            <= '0;
            j_reg            <= '0;
            e_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sel_reg          <= sel_next;
            inner_reg        <= inner_next;
            step_reg         <= step_next;
            cnt_reg          <= cnt_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            e_reg            <= e_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers and factor lists.
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        b_reg          <= b_next;
        d_reg          <= d_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        g_reg          <= g_next;
        mprime_reg     <= mprime_next;
        last_prime_reg <= last_prime_next;
        cur_pow_reg    <= cur_pow_next;
        prime_reg      <= prime_next;
        power_reg      <= power_next;
        divisor_reg    <= divisor_next;
        status_reg     <= status_next;
    end

    // Checks on the sequencer and the result.
    `include "gcd_by_prime_factorization_assert.svh"

    `GCDPF_ASSERT_ALWAYS(a_no_overlap, !(item_ready && result_valid),
        "ready while a result waits")
    `GCDPF_ASSERT_IMPLIES(a_undefined_zero, result_valid && status == STATUS_UNDEFINED,
        divisor == '0, "undefined result carries a nonzero divisor")
    `GCDPF_ASSERT_IMPLIES(a_trial_odd, state_reg == S_DIV, d_reg[0],
        "trial divisor is even")
    `GCDPF_ASSERT_ALWAYS(a_list_bound,
        cnt_reg[0] <= CW'(MAX_PRIMES) && cnt_reg[1] <= CW'(MAX_PRIMES),
        "factor list count overflow")
    `GCDPF_ASSERT_NEXT(a_ready_after_result, result_valid && result_ready, item_ready,
        "not ready after result transfer")

endmodule
